[design/dfrs_pkg.sv]
package dfrs_pkg;

  localparam int unsigned HEIGHT_W   = 32;
  localparam int unsigned HELD_W     = 51;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned SIZE_W     = 20;
  localparam int unsigned RATE_W     = 61;
  localparam int unsigned WINDOW_W   = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = RATE_W;

  localparam int unsigned MPLIER_W = HEIGHT_W;
  localparam int unsigned SR_W     = RATE_W + MPLIER_W;
  localparam int unsigned CNT_W    = $clog2(SR_W + 1);

  localparam int unsigned SCALE_W = 10;

  localparam int unsigned BUD_MUL_STEPS  = PCT_W;
  localparam int unsigned CAP_MUL_STEPS  = SCALE_W;
  localparam int unsigned RAMP_MUL_STEPS = MPLIER_W;
  localparam int unsigned THR_MUL_STEPS  = PCT_W;
  localparam int unsigned BUD_DIV_STEPS  = RATE_W + BUD_MUL_STEPS;
  localparam int unsigned CAP_DIV_STEPS  = RATE_W + CAP_MUL_STEPS;
  localparam int unsigned RAMP_DIV_STEPS = RATE_W + RAMP_MUL_STEPS;
  localparam int unsigned THR_DIV_STEPS  = RATE_W + THR_MUL_STEPS;

  localparam logic [RATE_W-1:0]   FLOOR_RATE  = RATE_W'(1000);
  localparam logic [MPLIER_W-1:0] RATE_SCALE  = MPLIER_W'(1000);
  localparam logic [HEIGHT_W-1:0] PCT_DIVISOR = HEIGHT_W'(100);
  localparam logic [PCT_W-1:0]    PCT_MAX     = PCT_W'(100);

  typedef struct packed {
    logic [HEIGHT_W-1:0] start_height;
    logic [HEIGHT_W-1:0] deadline_height;
    logic [HELD_W-1:0]   held_value;
    logic [PCT_W-1:0]    budget_percent;
    logic [SIZE_W-1:0]   tx_size;
    logic [RATE_W-1:0]   start_rate;
    logic [PCT_W-1:0]    step_percent;
    logic [WINDOW_W-1:0] urgent_window;
  } cfg_t;

  typedef struct packed {
    logic                load_mul;
    logic                load_div;
    logic [RATE_W-1:0]   mcand;
    logic [MPLIER_W-1:0] mplier;
    logic [HEIGHT_W-1:0] divisor;
    logic [CNT_W-1:0]    steps;
  } su_cmd_t;

  typedef struct packed {
    logic            busy;
    logic [SR_W-1:0] acc;
  } su_stat_t;

endpackage

[design/dfrs_cfg_regs.sv]
module dfrs_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dfrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dfrs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output dfrs_pkg::cfg_t                  cfg_o
);
  import dfrs_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_HEIGHT    = 3'd0,
    CFG_DEADLINE_HEIGHT = 3'd1,
    CFG_HELD_VALUE      = 3'd2,
    CFG_BUDGET_PERCENT  = 3'd3,
    CFG_TX_SIZE         = 3'd4,
    CFG_START_RATE      = 3'd5,
    CFG_STEP_PERCENT    = 3'd6,
    CFG_URGENT_WINDOW   = 3'd7
  } cfg_idx_e;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_HEIGHT:    cfg_d.start_height    = cfg_data_i[HEIGHT_W-1:0];
        CFG_DEADLINE_HEIGHT: cfg_d.deadline_height = cfg_data_i[HEIGHT_W-1:0];
        CFG_HELD_VALUE:      cfg_d.held_value      = cfg_data_i[HELD_W-1:0];
        CFG_BUDGET_PERCENT:  cfg_d.budget_percent  = cfg_data_i[PCT_W-1:0];
        CFG_TX_SIZE:         cfg_d.tx_size         = cfg_data_i[SIZE_W-1:0];
        CFG_START_RATE:      cfg_d.start_rate      = cfg_data_i[RATE_W-1:0];
        CFG_STEP_PERCENT:    cfg_d.step_percent    = cfg_data_i[PCT_W-1:0];
        CFG_URGENT_WINDOW:   cfg_d.urgent_window   = cfg_data_i[WINDOW_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_height    <= HEIGHT_W'(0);
      cfg_q.deadline_height <= HEIGHT_W'(144);
      cfg_q.held_value      <= HELD_W'(0);
      cfg_q.budget_percent  <= PCT_W'(50);
      cfg_q.tx_size         <= SIZE_W'(1);
      cfg_q.start_rate      <= RATE_W'(1000);
      cfg_q.step_percent    <= PCT_W'(25);
      cfg_q.urgent_window   <= WINDOW_W'(6);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/dfrs_serial_unit.sv]
module dfrs_serial_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dfrs_pkg::su_cmd_t  cmd_i,
  output dfrs_pkg::su_stat_t stat_o
);
  import dfrs_pkg::*;

  logic [SR_W-1:0]     sr_q, sr_d;
  logic [RATE_W-1:0]   mc_q, mc_d;
  logic [HEIGHT_W-1:0] dvsr_q, dvsr_d;
  logic [HEIGHT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                div_q, div_d;

  logic [RATE_W:0]   mul_sum;
  logic [HEIGHT_W:0] rem_sh;
  logic [HEIGHT_W:0] rem_sub;
  logic              fits;

  always_comb begin
    mul_sum = {1'b0, sr_q[SR_W-1:MPLIER_W]} + (sr_q[0] ? {1'b0, mc_q} : '0);
    rem_sh  = {rem_q, sr_q[SR_W-1]};
    rem_sub = rem_sh - {1'b0, dvsr_q};
    fits    = rem_sh >= {1'b0, dvsr_q};

    sr_d   = sr_q;
    mc_d   = mc_q;
    dvsr_d = dvsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    div_d  = div_q;

    priority if (cmd_i.load_mul) begin
      sr_d  = {{RATE_W{1'b0}}, cmd_i.mplier};
      mc_d  = cmd_i.mcand;
      cnt_d = cmd_i.steps;
      div_d = 1'b0;
    end else if (cmd_i.load_div) begin
      rem_d  = '0;
      dvsr_d = cmd_i.divisor;
      cnt_d  = cmd_i.steps;
      div_d  = 1'b1;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (div_q) begin
        sr_d  = {sr_q[SR_W-2:0], fits};
        rem_d = fits ? rem_sub[HEIGHT_W-1:0] : rem_sh[HEIGHT_W-1:0];
      end else begin
        sr_d = {mul_sum, sr_q[MPLIER_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      div_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q   <= sr_d;
    mc_q   <= mc_d;
    dvsr_q <= dvsr_d;
    rem_q  <= rem_d;
  end

  assign stat_o.busy = cnt_q != '0;
  assign stat_o.acc  = sr_q;

endmodule

[design/deadline_fee_ramp_scheduler.sv]
// The single bit-serial multiply/divide unit walks one bit per cycle through eight passes
// when the height lies strictly inside the ramp window, and skips the ramp multiply and
// divide passes otherwise; one beat is worked on at a time.
// A finished result waits in the output register; input is stalled while busy.
// Reset (asynchronous, active low) loads the register defaults and clears state.
module deadline_fee_ramp_scheduler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dfrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dfrs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dfrs_pkg::KIND_W-1:0]     kind_i,
  input  logic [dfrs_pkg::HEIGHT_W-1:0]   block_height_i,
  input  logic [dfrs_pkg::RATE_W-1:0]     rate_used_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dfrs_pkg::RATE_W-1:0]     scheduled_rate_o,
  output logic [dfrs_pkg::RATE_W-1:0]     max_rate_o,
  output logic                            bump_now_o,
  output logic                            urgent_o,
  output logic                            expired_o,
  output logic                            is_confirmed_o,
  output logic [dfrs_pkg::HEIGHT_W-1:0]   blocks_left_o,
  output logic                            config_error_o
);
  import dfrs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_BROADCAST = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_CONFIRM   = KIND_W'(2);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_BUD_MUL  = 12'b000000000010,
    S_BUD_DIV  = 12'b000000000100,
    S_CAP_MUL  = 12'b000000001000,
    S_CAP_DIV  = 12'b000000010000,
    S_RAMP_SET = 12'b000000100000,
    S_RAMP_MUL = 12'b000001000000,
    S_RAMP_DIV = 12'b000010000000,
    S_THR_MUL  = 12'b000100000000,
    S_THR_DIV  = 12'b001000000000,
    S_DONE     = 12'b010000000000,
    S_SPAN     = 12'b100000000000
  } state_e;

  cfg_t     cfg;
  su_cmd_t  cmd;
  su_stat_t stat;
  su_cmd_t  thr_cmd;

  state_e state_q, state_d;

  logic [HEIGHT_W-1:0] h_q;
  logic [RATE_W-1:0]   last_rate_q;
  logic                confirmed_q;
  logic [RATE_W-1:0]   mx_q, mx_d;
  logic [RATE_W-1:0]   sched_q, sched_d;
  logic [RATE_W-1:0]   span_q, span_d;
  logic                bump_ge_q, bump_ge_d;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [RATE_W-1:0]   out_sched_q, out_mx_q;
  logic                out_bump_q, out_urg_q, out_exp_q, out_conf_q, out_err_q;
  logic [HEIGHT_W-1:0] out_left_q;

  logic                in_acc;
  logic                ahead, at_start, urg, expd, bump, err;
  logic [HEIGHT_W-1:0] left;
  logic [RATE_W-1:0]   cap_sat, cap;
  logic [RATE_W:0]     ramp_sum;
  logic [RATE_W-1:0]   ramp_rate;
  logic [RATE_W+1:0]   thr;

  dfrs_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  dfrs_serial_unit u_su (
    .clk_i,
    .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    ahead    = h_q < cfg.deadline_height;
    at_start = h_q <= cfg.start_height;
    left     = ahead ? cfg.deadline_height - h_q : '0;
    urg      = !confirmed_q && ahead &&
               (left <= {{(HEIGHT_W-WINDOW_W){1'b0}}, cfg.urgent_window});
    expd     = !confirmed_q && !ahead;
    bump     = !confirmed_q && ahead && (last_rate_q == '0 || urg || bump_ge_q);
    err      = cfg.deadline_height <= cfg.start_height || cfg.tx_size == '0 ||
               cfg.budget_percent == '0 || cfg.budget_percent > PCT_MAX ||
               cfg.start_rate < FLOOR_RATE;

    cap_sat  = (|stat.acc[CAP_DIV_STEPS-1:RATE_W]) ? '1 : stat.acc[RATE_W-1:0];
    cap      = (cfg.tx_size == '0) ? FLOOR_RATE :
               (cap_sat < cfg.start_rate) ? cfg.start_rate : cap_sat;

    ramp_sum  = {1'b0, cfg.start_rate} + {1'b0, stat.acc[RATE_W-1:0]};
    ramp_rate = (ramp_sum > {1'b0, mx_q}) ? mx_q : ramp_sum[RATE_W-1:0];

    thr = {2'b00, last_rate_q} + {1'b0, stat.acc[RATE_W:0]};

    thr_cmd          = '0;
    thr_cmd.load_mul = 1'b1;
    thr_cmd.mcand    = last_rate_q;
    thr_cmd.mplier   = {{(MPLIER_W-PCT_W){1'b0}}, cfg.step_percent};
    thr_cmd.steps    = CNT_W'(THR_MUL_STEPS);
  end

  always_comb begin
    state_d   = state_q;
    cmd       = '0;
    mx_d      = mx_q;
    sched_d   = sched_q;
    span_d    = span_q;
    bump_ge_d = bump_ge_q;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd.load_mul = 1'b1;
          cmd.mcand    = {{(RATE_W-HELD_W){1'b0}}, cfg.held_value};
          cmd.mplier   = {{(MPLIER_W-PCT_W){1'b0}}, cfg.budget_percent};
          cmd.steps    = CNT_W'(BUD_MUL_STEPS);
          state_d      = S_BUD_MUL;
        end
      end
      S_BUD_MUL: begin
        if (!stat.busy) begin
          cmd.load_div = 1'b1;
          cmd.divisor  = PCT_DIVISOR;
          cmd.steps    = CNT_W'(BUD_DIV_STEPS);
          state_d      = S_BUD_DIV;
        end
      end
      S_BUD_DIV: begin
        if (!stat.busy) begin
          cmd.load_mul = 1'b1;
          cmd.mcand    = stat.acc[RATE_W-1:0];
          cmd.mplier   = RATE_SCALE;
          cmd.steps    = CNT_W'(CAP_MUL_STEPS);
          state_d      = S_CAP_MUL;
        end
      end
      S_CAP_MUL: begin
        if (!stat.busy) begin
          cmd.load_div = 1'b1;
          cmd.divisor  = {{(HEIGHT_W-SIZE_W){1'b0}}, cfg.tx_size};
          cmd.steps    = CNT_W'(CAP_DIV_STEPS);
          state_d      = S_CAP_DIV;
        end
      end
      S_CAP_DIV: begin
        if (!stat.busy) begin
          mx_d    = cap;
          state_d = S_SPAN;
        end
      end
      S_SPAN: begin
        span_d  = (mx_q > cfg.start_rate) ? mx_q - cfg.start_rate : '0;
        state_d = S_RAMP_SET;
      end
      S_RAMP_SET: begin
        priority if (at_start) begin
          sched_d = cfg.start_rate;
          cmd     = thr_cmd;
          state_d = S_THR_MUL;
        end else if (!ahead) begin
          sched_d = mx_q;
          cmd     = thr_cmd;
          state_d = S_THR_MUL;
        end else begin
          cmd.load_mul = 1'b1;
          cmd.mcand    = span_q;
          cmd.mplier   = h_q - cfg.start_height;
          cmd.steps    = CNT_W'(RAMP_MUL_STEPS);
          state_d      = S_RAMP_MUL;
        end
      end
      S_RAMP_MUL: begin
        if (!stat.busy) begin
          cmd.load_div = 1'b1;
          cmd.divisor  = cfg.deadline_height - cfg.start_height;
          cmd.steps    = CNT_W'(RAMP_DIV_STEPS);
          state_d      = S_RAMP_DIV;
        end
      end
      S_RAMP_DIV: begin
        if (!stat.busy) begin
          sched_d = ramp_rate;
          cmd     = thr_cmd;
          state_d = S_THR_MUL;
        end
      end
      S_THR_MUL: begin
        if (!stat.busy) begin
          cmd.load_div = 1'b1;
          cmd.divisor  = PCT_DIVISOR;
          cmd.steps    = CNT_W'(THR_DIV_STEPS);
          state_d      = S_THR_DIV;
        end
      end
      S_THR_DIV: begin
        if (!stat.busy) begin
          bump_ge_d = {2'b00, sched_q} >= thr;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = (out_valid_q && out_stall_i) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      last_rate_q <= '0;
      confirmed_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        last_rate_q <= '0;
        confirmed_q <= 1'b0;
      end else if (in_acc) begin
        unique case (kind_i)
          KIND_BROADCAST: last_rate_q <= rate_used_i;
          KIND_CONFIRM:   confirmed_q <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      h_q <= block_height_i;
    end
    mx_q      <= mx_d;
    sched_q   <= sched_d;
    span_q    <= span_d;
    bump_ge_q <= bump_ge_d;
    if (out_load) begin
      out_sched_q <= sched_q;
      out_mx_q    <= mx_q;
      out_bump_q  <= bump;
      out_urg_q   <= urg;
      out_exp_q   <= expd;
      out_conf_q  <= confirmed_q;
      out_left_q  <= left;
      out_err_q   <= err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign scheduled_rate_o = out_sched_q;
  assign max_rate_o       = out_mx_q;
  assign bump_now_o       = out_bump_q;
  assign urgent_o         = out_urg_q;
  assign expired_o        = out_exp_q;
  assign is_confirmed_o   = out_conf_q;
  assign blocks_left_o    = out_left_q;
  assign config_error_o   = out_err_q;

endmodule

[design/dfrs_checker.sv]
module dfrs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [dfrs_pkg::RATE_W-1:0]   scheduled_rate_o,
  input logic                          bump_now_o,
  input logic                          urgent_o,
  input logic                          expired_o,
  input logic                          is_confirmed_o,
  input logic [dfrs_pkg::HEIGHT_W-1:0] blocks_left_o
);

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(scheduled_rate_o))
    else $error("stalled result beat dropped or changed");

  a_urgent_bumps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && urgent_o |-> bump_now_o && !expired_o && !is_confirmed_o)
    else $error("urgent result without bump or with expiry");

  a_expired_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expired_o |-> blocks_left_o == '0 && !bump_now_o && !urgent_o)
    else $error("expired result with blocks left or bump");

endmodule

bind deadline_fee_ramp_scheduler dfrs_checker u_dfrs_checker (.*);

[dv/deadline_fee_ramp_scheduler_test.sv]
module deadline_fee_ramp_scheduler_test;
  import dfrs_pkg::*;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK,
    KIND_BROADCAST,
    KIND_CONFIRM,
    KIND_SPARE
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HEIGHT,
    REG_DEADLINE_HEIGHT,
    REG_HELD_VALUE,
    REG_BUDGET_PERCENT,
    REG_TX_SIZE,
    REG_START_RATE,
    REG_STEP_PERCENT,
    REG_URGENT_WINDOW
  } reg_index_e;

  typedef struct packed {
    logic [RATE_W-1:0]   scheduled_rate;
    logic [RATE_W-1:0]   max_rate;
    logic                bump_now;
    logic                urgent;
    logic                expired;
    logic                is_confirmed;
    logic [HEIGHT_W-1:0] blocks_left;
    logic                config_error;
  } fee_plan_t;

  localparam logic [RATE_W-1:0] RATE_ALL_ONES = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [KIND_W-1:0]     kind_i = '0;
  logic [HEIGHT_W-1:0]   block_height_i = '0;
  logic [RATE_W-1:0]     rate_used_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [RATE_W-1:0]     scheduled_rate_o;
  logic [RATE_W-1:0]     max_rate_o;
  logic                  bump_now_o;
  logic                  urgent_o;
  logic                  expired_o;
  logic                  is_confirmed_o;
  logic [HEIGHT_W-1:0]   blocks_left_o;
  logic                  config_error_o;

  deadline_fee_ramp_scheduler DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .block_height_i   (block_height_i),
    .rate_used_i      (rate_used_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scheduled_rate_o (scheduled_rate_o),
    .max_rate_o       (max_rate_o),
    .bump_now_o       (bump_now_o),
    .urgent_o         (urgent_o),
    .expired_o        (expired_o),
    .is_confirmed_o   (is_confirmed_o),
    .blocks_left_o    (blocks_left_o),
    .config_error_o   (config_error_o)
  );

  cfg_t                model_cfg;
  logic [RATE_W-1:0]   recorded_rate;
  logic                sweep_confirmed;
  fee_plan_t           plans_due[$];
  logic                last_bump;
  logic [RATE_W-1:0]   last_planned_rate;
  int unsigned         send_idle_pct = 8;
  int unsigned         recv_stall_pct = 81;
  int unsigned         n_items_sent = 0;
  int unsigned         n_results_checked = 0;
  int unsigned         n_settings = 1;
  int unsigned         n_errors = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic fee_plan_t plan_fee(input kind_e k, input logic [HEIGHT_W-1:0] h,
                                         input logic [RATE_W-1:0] r);
    fee_plan_t    p;
    logic [127:0] ceiling;
    logic [127:0] planned;
    logic [127:0] rise;
    logic [127:0] threshold;
    logic         ahead;
    if (k == KIND_BROADCAST) begin
      recorded_rate = r;
    end else if (k == KIND_CONFIRM) begin
      sweep_confirmed = 1'b1;
    end
    if (model_cfg.tx_size == '0) begin
      ceiling = 128'(FLOOR_RATE);
    end else begin
      ceiling = 128'(model_cfg.held_value) * model_cfg.budget_percent / PCT_DIVISOR;
      ceiling = ceiling * RATE_SCALE / model_cfg.tx_size;
      if (ceiling > RATE_ALL_ONES) ceiling = 128'(RATE_ALL_ONES);
      if (ceiling < model_cfg.start_rate) ceiling = 128'(model_cfg.start_rate);
    end
    if (h <= model_cfg.start_height) begin
      planned = 128'(model_cfg.start_rate);
    end else if (h >= model_cfg.deadline_height) begin
      planned = ceiling;
    end else begin
      rise = (ceiling > model_cfg.start_rate) ? ceiling - model_cfg.start_rate : '0;
      planned = 128'(model_cfg.start_rate) + rise * (128'(h) - model_cfg.start_height)
                / (128'(model_cfg.deadline_height) - model_cfg.start_height);
      if (planned > ceiling) planned = ceiling;
    end
    threshold = 128'(recorded_rate) + 128'(recorded_rate) / PCT_DIVISOR * model_cfg.step_percent
              + 128'(recorded_rate) % PCT_DIVISOR * model_cfg.step_percent / PCT_DIVISOR;
    ahead = h < model_cfg.deadline_height;
    p.scheduled_rate = planned[RATE_W-1:0];
    p.max_rate       = ceiling[RATE_W-1:0];
    p.blocks_left    = ahead ? model_cfg.deadline_height - h : '0;
    p.urgent         = !sweep_confirmed && ahead && p.blocks_left <= model_cfg.urgent_window;
    p.expired        = !sweep_confirmed && !ahead;
    p.is_confirmed   = sweep_confirmed;
    p.bump_now       = !sweep_confirmed && ahead &&
                       (recorded_rate == '0 || p.urgent || planned >= threshold);
    p.config_error   = model_cfg.deadline_height <= model_cfg.start_height ||
                       model_cfg.tx_size == '0 || model_cfg.budget_percent < 1 ||
                       model_cfg.budget_percent > PCT_MAX || model_cfg.start_rate < FLOOR_RATE;
    return p;
  endfunction

  function automatic logic [RATE_W-1:0] rand_rate();
    return RATE_W'({$urandom, $urandom}) >> $urandom_range(RATE_W - 1);
  endfunction

  function automatic logic [HEIGHT_W-1:0] rand_height();
    return HEIGHT_W'($urandom) >> $urandom_range(HEIGHT_W - 1);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t                c;
    logic [HEIGHT_W-1:0] span;
    int unsigned         pick;
    c.start_height = ($urandom_range(9) == 0) ? '0 : HEIGHT_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) span = '0;
    else if (pick < 12) span = HEIGHT_W'(0) - HEIGHT_W'($urandom_range(1000, 1));
    else if (pick < 20) span = HEIGHT_W'($urandom);
    else span = HEIGHT_W'($urandom_range(400, 1));
    c.deadline_height = c.start_height + span;
    pick = $urandom_range(99);
    if (pick < 5) c.held_value = '0;
    else if (pick < 10) c.held_value = '1;
    else c.held_value = HELD_W'({$urandom, $urandom}) >> $urandom_range(30);
    c.budget_percent = ($urandom_range(9) == 0) ? PCT_W'($urandom_range(127))
                                                : PCT_W'($urandom_range(100, 1));
    pick = $urandom_range(99);
    if (pick < 5) c.tx_size = '0;
    else if (pick < 10) c.tx_size = '1;
    else c.tx_size = SIZE_W'($urandom_range(1000000, 60));
    pick = $urandom_range(99);
    if (pick < 80) c.start_rate = RATE_W'($urandom_range(100000, 1000));
    else if (pick < 90) c.start_rate = RATE_W'($urandom_range(999));
    else c.start_rate = rand_rate();
    c.step_percent = ($urandom_range(4) == 0) ? PCT_W'($urandom_range(127))
                                              : PCT_W'($urandom_range(50, 1));
    c.urgent_window = ($urandom_range(6) == 0) ? WINDOW_W'($urandom_range(65535))
                                               : WINDOW_W'($urandom_range(30));
    return c;
  endfunction

  task automatic report_fault(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_fault($sformatf("result %0d %s got %0d expected %0d",
                             n_results_checked, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    fee_plan_t want;
    if (out_valid_o && !out_stall_i) begin
      n_results_checked++;
      if (plans_due.size() == 0) begin
        report_fault($sformatf("result %0d arrived with nothing outstanding",
                               n_results_checked));
      end else begin
        want = plans_due.pop_front();
        check_field("scheduled_rate", 64'(scheduled_rate_o), 64'(want.scheduled_rate));
        check_field("max_rate", 64'(max_rate_o), 64'(want.max_rate));
        check_field("bump_now", 64'(bump_now_o), 64'(want.bump_now));
        check_field("urgent", 64'(urgent_o), 64'(want.urgent));
        check_field("expired", 64'(expired_o), 64'(want.expired));
        check_field("is_confirmed", 64'(is_confirmed_o), 64'(want.is_confirmed));
        check_field("blocks_left", 64'(blocks_left_o), 64'(want.blocks_left));
        check_field("config_error", 64'(config_error_o), 64'(want.config_error));
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic submit_event(input kind_e k, input logic [HEIGHT_W-1:0] h,
                              input logic [RATE_W-1:0] r);
    fee_plan_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    block_height_i <= h;
    rate_used_i    <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = plan_fee(k, h, r);
    plans_due.push_back(p);
    last_bump = p.bump_now;
    last_planned_rate = p.scheduled_rate;
    n_items_sent++;
  endtask

  task automatic wait_settled();
    in_valid_i <= 1'b0;
    while (plans_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t c);
    wait_settled();
    write_reg(REG_START_HEIGHT, CFG_DATA_W'(c.start_height));
    write_reg(REG_DEADLINE_HEIGHT, CFG_DATA_W'(c.deadline_height));
    write_reg(REG_HELD_VALUE, CFG_DATA_W'(c.held_value));
    write_reg(REG_BUDGET_PERCENT, CFG_DATA_W'(c.budget_percent));
    write_reg(REG_TX_SIZE, CFG_DATA_W'(c.tx_size));
    write_reg(REG_START_RATE, CFG_DATA_W'(c.start_rate));
    write_reg(REG_STEP_PERCENT, CFG_DATA_W'(c.step_percent));
    write_reg(REG_URGENT_WINDOW, CFG_DATA_W'(c.urgent_window));
    cfg_we_i <= 1'b0;
    model_cfg = c;
    recorded_rate = '0;
    sweep_confirmed = 1'b0;
    n_settings++;
  endtask

  task automatic test_reset_defaults();
    submit_event(KIND_TICK, 32'd0, rand_rate());
    submit_event(KIND_TICK, 32'd72, rand_rate());
    submit_event(KIND_BROADCAST, 32'd100, RATE_W'(1000));
    submit_event(KIND_TICK, 32'd140, rand_rate());
    submit_event(KIND_TICK, 32'd144, rand_rate());
    submit_event(KIND_CONFIRM, 32'd150, rand_rate());
  endtask

  task automatic test_register_extremes();
    load_settings('{start_height: '0, deadline_height: '1, held_value: '1,
                    budget_percent: '1, tx_size: SIZE_W'(1), start_rate: FLOOR_RATE,
                    step_percent: '1, urgent_window: '1});
    submit_event(KIND_TICK, 32'd1, '0);
    submit_event(KIND_TICK, 32'h7FFF_FFFF, rand_rate());
    submit_event(KIND_BROADCAST, 32'hFFFF_FFFE, '1);
    submit_event(KIND_SPARE, '1, rand_rate());
    // deadline before start, zero size, zero budget, zero rate: all set-up checks but the over-100 budget fail
    load_settings('{start_height: '1, deadline_height: '0, held_value: '0,
                    budget_percent: '0, tx_size: '0, start_rate: '0,
                    step_percent: '0, urgent_window: '0});
    submit_event(KIND_TICK, '1, rand_rate());
    submit_event(KIND_TICK, '0, rand_rate());
    submit_event(KIND_BROADCAST, 32'd5, '0);
    load_settings('{start_height: 32'd100, deadline_height: 32'd100,
                    held_value: HELD_W'(12345), budget_percent: PCT_W'(101),
                    tx_size: '1, start_rate: '1, step_percent: PCT_W'(100),
                    urgent_window: WINDOW_W'(3)});
    submit_event(KIND_TICK, 32'd100, rand_rate());
    submit_event(KIND_TICK, 32'd101, rand_rate());
  endtask

  task automatic test_replacement_threshold();
    load_settings('{start_height: 32'd1000, deadline_height: 32'd1100,
                    held_value: HELD_W'(1_000_000_000), budget_percent: PCT_W'(100),
                    tx_size: SIZE_W'(1000), start_rate: FLOOR_RATE,
                    step_percent: PCT_W'(10), urgent_window: WINDOW_W'(5)});
    submit_event(KIND_BROADCAST, 32'd1001, RATE_W'(10_000_099));
    submit_event(KIND_TICK, 32'd1001, rand_rate());
    submit_event(KIND_TICK, 32'd1002, rand_rate());
    submit_event(KIND_CONFIRM, 32'd1003, rand_rate());
    submit_event(KIND_TICK, 32'd1099, rand_rate());
  endtask

  task automatic run_sweep(input int unsigned n_steps);
    logic [HEIGHT_W-1:0] h;
    logic [HEIGHT_W-1:0] span;
    logic [HEIGHT_W-1:0] stride;
    int unsigned         roll;
    span = model_cfg.deadline_height - model_cfg.start_height;
    stride = (span / 10 > 1) ? span / 10 : 1;
    h = model_cfg.start_height - HEIGHT_W'($urandom_range(3));
    repeat (n_steps) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        submit_event(kind_e'($urandom_range(3)), rand_height(), rand_rate());
      end else if (roll < 13) begin
        submit_event(KIND_CONFIRM, h, rand_rate());
      end else if (last_bump && roll < 65) begin
        submit_event(KIND_BROADCAST, h, last_planned_rate);
      end else begin
        submit_event(($urandom_range(19) == 0) ? KIND_SPARE : KIND_TICK, h, rand_rate());
      end
      // walk block by block through the urgent window and the two blocks before it
      if (h < model_cfg.deadline_height &&
          model_cfg.deadline_height - h <= HEIGHT_W'(model_cfg.urgent_window) + 2) begin
        h = h + 1;
      end else begin
        h = h + HEIGHT_W'($urandom_range(stride, 1));
      end
    end
  endtask

  task automatic test_random_sweeps(input int unsigned send_pct, input int unsigned recv_pct,
                                    input int unsigned n_target);
    int unsigned goal;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    goal = n_items_sent + n_target;
    while (n_items_sent < goal) begin
      load_settings(random_settings());
      run_sweep($urandom_range(40, 12));
    end
  endtask

  initial begin
    model_cfg = '{start_height: '0, deadline_height: 32'd144, held_value: '0,
                  budget_percent: PCT_W'(50), tx_size: SIZE_W'(1), start_rate: FLOOR_RATE,
                  step_percent: PCT_W'(25), urgent_window: WINDOW_W'(6)};
    recorded_rate = '0;
    sweep_confirmed = 1'b0;
    last_bump = 1'b0;
    last_planned_rate = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_replacement_threshold();
    test_random_sweeps(8, 81, 170);
    test_random_sweeps(81, 8, 170);
    test_random_sweeps(0, 0, 170);
    wait_settled();
    repeat (400) @(posedge clk_i);
    $display("Sent %0d block events, checked %0d results over %0d register settings,",
             n_items_sent, n_results_checked, n_settings);
    $display("with ramp sweeps, replacements, confirmations and stalls on both sides.");
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Timed out with %0d results outstanding", plans_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
